>>> rtl/rit_pkg.sv
package rit_pkg;

    localparam logic [6:0] C_ASCII_NUL   = 7'h00;
    localparam logic [6:0] C_ASCII_ZERO  = 7'h30;
    localparam logic [6:0] C_ASCII_MINUS = 7'h2D;
    localparam logic [6:0] C_LETTER_GAP  = 7'd7;
    localparam logic [5:0] C_MAX_DIGIT   = 6'd9;
    localparam logic [5:0] C_MIN_RADIX   = 6'd2;
    localparam logic [5:0] C_MAX_RADIX   = 6'd35;
    localparam logic [5:0] C_TEN         = 6'd10;
    localparam logic [5:0] C_RADIX_AUTO  = 6'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_DWAIT,
        S_SIGN,
        S_READ,
        S_EMIT
    } t_state;

    function automatic logic [6:0] digit_char(input logic [5:0] d);
        logic [6:0] c;
        c = C_ASCII_ZERO + {1'b0, d};
        if (d > C_MAX_DIGIT) begin
            c = c + C_LETTER_GAP;
        end
        return c;
    endfunction

endpackage

>>> rtl/rit_ram.sv
module rit_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 33
) (
    input  logic                     i_clk,
    input  logic                     i_wen,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/rit_divider.sv
module rit_divider #(
    parameter int W = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [5:0]  i_divisor,
    output logic        o_done,
    output logic [W-1:0] o_quotient,
    output logic [5:0]  o_remainder
);

    localparam int CW = $clog2(W);

    logic          r_run, n_run;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_work, n_work;
    logic [5:0]    r_rem, n_rem;
    logic [5:0]    r_div, n_div;
    logic [6:0]    w_trial;
    logic          w_ge;

    assign w_trial = {r_rem, r_work[W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_work = r_work;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_run  = 1'b1;
            n_cnt  = CW'(W - 1);
            n_work = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_run) begin
            n_work = {r_work[W-2:0], w_ge};
            n_rem  = w_ge ? 6'(w_trial - {1'b0, r_div}) : w_trial[5:0];
            n_cnt  = r_cnt - CW'(1);
            if (r_cnt == '0) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_work <= n_work;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_work;
    assign o_remainder = r_rem;

endmodule

>>> rtl/radix_integer_to_ascii.sv
// Channel  | Direction | Handshake                          | Payload
// command  | in        | start & !busy                      | i_value
// config   | in        | i_radix_valid & o_radix_ready      | i_radix
// result   | out       | o_valid, one cycle, no backpressure | o_char_code, o_last
//
// Each digit is computed in the bit-serial divider, one quotient bit per cycle;
// the digits are then read back from the digit RAM through S_READ and S_EMIT,
// one character per pass, after a minus sign from S_SIGN for a negative value.
// Busy is held for the whole item; its last character is presented in the first
// cycle with busy low. Zero and an invalid radix give one result the next cycle.
// Synchronous active-low reset returns to idle with radix ten. Results cannot stall.
module radix_integer_to_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic                         i_radix_valid,
    output logic                         o_radix_ready,
    input  logic [5:0]                   i_radix,
    output logic                         o_valid,
    output logic [6:0]                   o_char_code,
    output logic                         o_last
);

    localparam int DEPTH = VALUE_BITS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    rit_pkg::t_state    r_state, n_state;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [5:0]            r_radix;
    logic [5:0]            r_div, n_div;
    logic                  r_neg, n_neg;
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_valid, n_valid;
    logic [6:0]            r_char, n_char;
    logic                  r_last, n_last;

    logic [5:0]            w_eff_radix;
    logic                  w_radix_ok;
    logic [VALUE_BITS-1:0] w_quot;
    logic [5:0]            w_rem;
    logic [5:0]            w_rdata;
    logic                  w_wen;
    logic [AW-1:0]         w_raddr;
    logic                  w_accept;

    assign w_accept    = start && !busy;
    assign w_eff_radix = (r_radix == rit_pkg::C_RADIX_AUTO) ? rit_pkg::C_TEN : r_radix;
    assign w_radix_ok  = (w_eff_radix >= rit_pkg::C_MIN_RADIX)
                      && (w_eff_radix <= rit_pkg::C_MAX_RADIX);
    assign w_div_start = (r_state == rit_pkg::S_DIV);
    assign w_wen       = (r_state == rit_pkg::S_DWAIT) && w_div_done;
    assign w_raddr     = AW'(r_count - CW'(1));

    rit_divider #(.W(VALUE_BITS)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (r_mag),
        .i_divisor   (r_div),
        .o_done      (w_div_done),
        .o_quotient  (w_quot),
        .o_remainder (w_rem)
    );

    rit_ram #(.WIDTH(6), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_wen   (w_wen),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_rem),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rit_pkg::S_IDLE: begin
                if (w_accept && w_radix_ok && (i_value != '0)) begin
                    n_state = rit_pkg::S_DIV;
                end
            end
            rit_pkg::S_DIV: n_state = rit_pkg::S_DWAIT;
            rit_pkg::S_DWAIT: begin
                if (w_div_done) begin
                    if (w_quot != '0) begin
                        n_state = rit_pkg::S_DIV;
                    end else if (r_neg) begin
                        n_state = rit_pkg::S_SIGN;
                    end else begin
                        n_state = rit_pkg::S_READ;
                    end
                end
            end
            rit_pkg::S_SIGN: n_state = rit_pkg::S_READ;
            rit_pkg::S_READ: n_state = rit_pkg::S_EMIT;
            rit_pkg::S_EMIT: begin
                if (r_count == CW'(1)) begin
                    n_state = rit_pkg::S_IDLE;
                end else begin
                    n_state = rit_pkg::S_READ;
                end
            end
            default: n_state = rit_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_div   = r_div;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_count = r_count;
        n_valid = 1'b0;
        n_char  = r_char;
        n_last  = r_last;
        case (r_state)
            rit_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_div   = w_eff_radix;
                    n_neg   = i_value[VALUE_BITS-1];
                    n_mag   = i_value[VALUE_BITS-1] ? VALUE_BITS'(~i_value + 1'b1)
                                                    : VALUE_BITS'(i_value);
                    n_count = '0;
                    if (!w_radix_ok) begin
                        n_valid = 1'b1;
                        n_char  = rit_pkg::C_ASCII_NUL;
                        n_last  = 1'b1;
                    end else if (i_value == '0) begin
                        n_valid = 1'b1;
                        n_char  = rit_pkg::C_ASCII_ZERO;
                        n_last  = 1'b1;
                    end
                end
            end
            rit_pkg::S_DWAIT: begin
                if (w_div_done) begin
                    n_mag   = w_quot;
                    n_count = r_count + CW'(1);
                end
            end
            rit_pkg::S_SIGN: begin
                n_valid = 1'b1;
                n_char  = rit_pkg::C_ASCII_MINUS;
                n_last  = 1'b0;
            end
            rit_pkg::S_EMIT: begin
                n_valid = 1'b1;
                n_char  = rit_pkg::digit_char(w_rdata);
                n_last  = (r_count == CW'(1));
                n_count = r_count - CW'(1);
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rit_pkg::S_IDLE;
            r_radix <= rit_pkg::C_TEN;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            if (i_radix_valid && o_radix_ready) begin
                r_radix <= i_radix;
            end
        end
        r_div  <= n_div;
        r_neg  <= n_neg;
        r_mag  <= n_mag;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign busy          = (r_state != rit_pkg::S_IDLE);
    assign o_radix_ready = 1'b1;
    assign o_valid       = r_valid;
    assign o_char_code   = r_char;
    assign o_last        = r_last;

endmodule

>>> tb/sv/radix_integer_to_ascii_test.sv
`timescale 1ns / 1ps

module radix_integer_to_ascii_test;

    localparam int VALUE_BITS    = 32;
    localparam int MAX_GAP       = 12;
    localparam int SETTLE_CYCLES = 40;
    localparam int RESET_CYCLES  = 11;
    localparam int LIMIT_CYCLES  = 1_500_000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 21;

    localparam logic [31:0] MOST_NEGATIVE = 32'h8000_0000;
    localparam logic [31:0] MOST_POSITIVE = 32'h7FFF_FFFF;
    localparam logic [31:0] MINUS_ONE     = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [6:0] char_code;
        logic       last;
    } t_text_char;

    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         start         = 1'b0;
    logic                         busy;
    logic signed [VALUE_BITS-1:0] i_value       = '0;
    logic                         i_radix_valid = 1'b0;
    logic                         o_radix_ready;
    logic [5:0]                   i_radix       = '0;
    logic                         o_valid;
    logic [6:0]                   o_char_code;
    logic                         o_last;

    t_text_char expected_chars[$];
    logic [5:0] model_radix = rit_pkg::C_TEN;
    bit         burst_mode  = 1'b0;
    int         fail_count  = 0;
    int         cycle_count = 0;

    radix_integer_to_ascii #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_value      (i_value),
        .i_radix_valid(i_radix_valid),
        .o_radix_ready(o_radix_ready),
        .i_radix      (i_radix),
        .o_valid      (o_valid),
        .o_char_code  (o_char_code),
        .o_last       (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_valid) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected character: char_code %0d, last %0d", o_char_code, o_last);
                fail_count++;
            end else begin
                want = expected_chars.pop_front();
                if (o_char_code !== want.char_code) begin
                    $error("char_code: expected %0d, actual %0d", want.char_code, o_char_code);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [5:0] effective_base(input logic [5:0] r);
        return (r == rit_pkg::C_RADIX_AUTO) ? rit_pkg::C_TEN : r;
    endfunction

    task automatic predict_text(input logic [31:0] value);
        logic [5:0]  base;
        logic [31:0] magnitude;
        logic [31:0] divisor;
        logic [5:0]  digits[0:VALUE_BITS];
        logic [6:0]  ch;
        int          count;
        base = effective_base(model_radix);
        if (base < rit_pkg::C_MIN_RADIX || base > rit_pkg::C_MAX_RADIX) begin
            expected_chars.push_back('{rit_pkg::C_ASCII_NUL, 1'b1});
        end else if (value == '0) begin
            expected_chars.push_back('{rit_pkg::C_ASCII_ZERO, 1'b1});
        end else begin
            divisor   = {26'd0, base};
            magnitude = value[31] ? (~value + 32'd1) : value;
            count     = 0;
            while (magnitude != '0) begin
                digits[count] = 6'(magnitude % divisor);
                magnitude     = magnitude / divisor;
                count++;
            end
            if (value[31]) begin
                expected_chars.push_back('{rit_pkg::C_ASCII_MINUS, 1'b0});
            end
            for (int i = count - 1; i >= 0; i--) begin
                ch = rit_pkg::C_ASCII_ZERO + {1'b0, digits[i]};
                if (digits[i] > rit_pkg::C_MAX_DIGIT) begin
                    ch = ch + rit_pkg::C_LETTER_GAP;
                end
                expected_chars.push_back('{ch, (i == 0)});
            end
        end
    endtask

    // keep start high across back-to-back transactions
    task automatic send_value(input logic [31:0] v);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (busy);
        predict_text(v);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_radix(input logic [5:0] r);
        settle();
        i_radix_valid <= 1'b1;
        i_radix       <= r;
        do @(posedge i_clk); while (!o_radix_ready);
        i_radix_valid <= 1'b0;
        model_radix = r;
    endtask

    function automatic logic [31:0] random_value(input logic [5:0] base);
        logic [31:0] v;
        logic [63:0] p;
        logic [63:0] b;
        int          k;
        b = (base < rit_pkg::C_MIN_RADIX || base > rit_pkg::C_MAX_RADIX)
            ? 64'd10 : {58'd0, base};
        case ($urandom_range(0, 5))
            1: begin
                v = $urandom_range(0, 100);
            end
            2: begin
                case ($urandom_range(0, 3))
                    0: v = MOST_NEGATIVE;
                    1: v = MOST_POSITIVE;
                    2: v = MINUS_ONE;
                    default: v = 32'd1;
                endcase
                return v;
            end
            3: begin
                p = 64'd1;
                k = $urandom_range(1, 31);
                repeat (k) begin
                    if (p * b <= {32'd0, MOST_NEGATIVE}) begin
                        p = p * b;
                    end
                end
                v = p[31:0] - 32'($urandom_range(0, 1));
            end
            4: begin
                v = $urandom >> $urandom_range(0, 31);
            end
            default: begin
                return $urandom;
            end
        endcase
        if ($urandom_range(0, 1) == 1) begin
            v = ~v + 32'd1;
        end
        return v;
    endfunction

    task automatic test_default_radix();
        send_value(32'd0);
        send_value(32'd1);
        send_value(MINUS_ONE);
        send_value(MOST_POSITIVE);
        send_value(MOST_NEGATIVE);
        send_value(32'd9);
        send_value(32'd10);
        send_value(-32'sd10);
    endtask

    task automatic test_radix_extremes();
        write_radix(rit_pkg::C_MIN_RADIX);
        send_value(MOST_NEGATIVE);
        send_value(MOST_POSITIVE);
        send_value(32'd1);
        send_value(MINUS_ONE);
        write_radix(rit_pkg::C_MAX_RADIX);
        send_value(32'd34);
        send_value(32'd35);
        send_value(MOST_NEGATIVE);
        write_radix(rit_pkg::C_MAX_RADIX + 6'd1);
        send_value(32'd5);
        write_radix(6'd1);
        send_value(32'd0);
        write_radix(6'd63);
        send_value(MINUS_ONE);
        write_radix(rit_pkg::C_RADIX_AUTO);
        send_value(32'd123456789);
        send_value(MOST_NEGATIVE);
        write_radix(6'd16);
        send_value(32'hDEAD_BEEF);
    endtask

    task automatic test_random_phases();
        logic [5:0] r;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 7))
                0: r = ($urandom_range(0, 1) == 1) ? 6'd1 : 6'($urandom_range(36, 63));
                1: r = rit_pkg::C_RADIX_AUTO;
                2: r = rit_pkg::C_MIN_RADIX;
                3: r = rit_pkg::C_MAX_RADIX;
                default: r = 6'($urandom_range(2, 35));
            endcase
            write_radix(r);
            burst_mode = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS) send_value(random_value(effective_base(r)));
            burst_mode = 1'b0;
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_radix();
        test_radix_extremes();
        test_random_phases();
        settle();
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
